@@ design/cwc_pkg.sv @@
package cwc_pkg;

  // Event kinds carried on the input tuser
  typedef enum logic [1:0] {
    MODE_ACK       = 2'd0,
    MODE_TIMEOUT   = 2'd1,
    MODE_ROUND_END = 2'd2
  } mode_t;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_INITIAL_THRESHOLD = 1'b0,
    CFG_DUP_ACK_LIMIT     = 1'b1
  } cfg_idx_t;

  localparam int THRESH_BITS = 16;
  localparam int SEQ_BITS    = 32;
  localparam int DUP_BITS    = 3;
  localparam int CFG_BITS    = 16;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 16'd32767;
  localparam logic [THRESH_BITS-1:0] THRESH_MAX   = 16'hFFFF;
  localparam logic [DUP_BITS-1:0]    DUP_LIMIT_RESET = 3'd3;

  // Window-independent part of the engine state
  typedef struct packed {
    logic [THRESH_BITS-1:0] threshold;
    logic [SEQ_BITS-1:0]    base_seqno;
    logic [DUP_BITS-1:0]    dup_count;
    logic                   ss_active;
    logic                   last_ack_good;
  } cwc_state_t;

  // Per-event flags reported with the result
  typedef struct packed {
    logic duplicate_seen;
    logic window_halved;
  } cwc_flags_t;

endpackage

@@ design/cwc_update.sv @@
module cwc_update #(
  parameter int WINDOW_BITS = 16
) (
  input  cwc_pkg::mode_t                mode,
  input  logic [cwc_pkg::SEQ_BITS-1:0]  ack_number,
  input  logic [cwc_pkg::DUP_BITS-1:0]  dup_ack_limit,
  input  logic [WINDOW_BITS-1:0]        window_cur,
  input  cwc_pkg::cwc_state_t           state_cur,
  output logic [WINDOW_BITS-1:0]        window_nxt,
  output cwc_pkg::cwc_state_t           state_nxt,
  output cwc_pkg::cwc_flags_t           flags
);

  localparam int CW = ((WINDOW_BITS > cwc_pkg::THRESH_BITS) ?
                       WINDOW_BITS : cwc_pkg::THRESH_BITS) + 1;

  logic [CW-1:0]                     win_ext;
  logic [CW-1:0]                     thr_ext;
  logic [CW-1:0]                     win_max_ext;
  logic [CW-1:0]                     grown;
  logic [cwc_pkg::THRESH_BITS-1:0]   win_sat;
  logic [cwc_pkg::SEQ_BITS-1:0]      seq_plus;
  logic [cwc_pkg::SEQ_BITS-1:0]      ack_back;
  logic [cwc_pkg::DUP_BITS-1:0]      dup_inc;

  assign win_ext     = CW'(window_cur);
  assign thr_ext     = CW'(state_cur.threshold);
  assign win_max_ext = CW'({WINDOW_BITS{1'b1}});
  assign win_sat     = (win_ext > CW'(cwc_pkg::THRESH_MAX)) ? cwc_pkg::THRESH_MAX
                                                            : win_ext[cwc_pkg::THRESH_BITS-1:0];
  assign seq_plus    = state_cur.base_seqno + 32'd1;
  assign ack_back    = ack_number - 32'd1;
  assign dup_inc     = state_cur.dup_count + 3'd1;

  // Double below threshold in slow start, else add one; clamp to window max
  always_comb begin
    if (state_cur.ss_active && (win_ext < thr_ext)) begin
      grown = win_ext << 1;
    end else begin
      grown = win_ext + CW'(1);
    end
    if (grown > win_max_ext) begin
      grown = win_max_ext;
    end
  end

  always_comb begin
    window_nxt = window_cur;
    state_nxt  = state_cur;
    flags      = '0;
    case (mode)
      cwc_pkg::MODE_ACK: begin
        if (ack_number == seq_plus) begin
          state_nxt.dup_count     = '0;
          state_nxt.base_seqno    = seq_plus;
          state_nxt.last_ack_good = 1'b1;
        end else begin
          if (ack_back < state_cur.base_seqno) begin
            state_nxt.base_seqno = ack_back;
          end
          flags.duplicate_seen    = 1'b1;
          state_nxt.dup_count     = dup_inc;
          state_nxt.last_ack_good = 1'b0;
          if (dup_inc == dup_ack_limit) begin
            state_nxt.threshold  = win_sat;
            window_nxt           = window_cur >> 1;
            state_nxt.dup_count  = '0;
            state_nxt.ss_active  = 1'b0;
            flags.window_halved  = 1'b1;
          end
        end
      end
      cwc_pkg::MODE_TIMEOUT: begin
        state_nxt.threshold     = win_sat;
        window_nxt              = WINDOW_BITS'(1);
        state_nxt.ss_active     = 1'b1;
        state_nxt.last_ack_good = 1'b0;
      end
      cwc_pkg::MODE_ROUND_END: begin
        if (state_cur.last_ack_good) begin
          window_nxt = grown[WINDOW_BITS-1:0];
        end
      end
      default: begin
        // unused kind: hold state, flags stay low
      end
    endcase
  end

endmodule

@@ design/congestion_window_control_unit.sv @@
// Congestion-window engine for a windowed sender, Reno style. Each request on
// the input stream is one event: an acknowledgement (tuser = 0, ack number in
// tdata), a timeout (tuser = 1) or the end of a sending round (tuser = 2); each
// event yields exactly one result carrying the window, threshold, expected
// sequence number and flags after that event. Events are taken at one per
// cycle while the result side keeps up: an input register feeds a single pass
// of compare/shift/add logic that updates the state and loads the result
// register, so out_tvalid is driven by the result register, which the event
// reaches by way of the input register. Write configuration only when the
// block is idle; writing initial_threshold also loads the working threshold
// at once.
module congestion_window_control_unit #(
  parameter int WINDOW_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input events
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] ack_number
  input  logic [1:0]  in_tuser,   // [1:0] mode
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] window_size, [31:16] slow_start_limit, [63:32] next_seqno,
  // [64] in_slow_start, [65] duplicate_seen, [66] window_halved, [71:67] zero
  output logic [71:0] out_tdata,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [cwc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [cwc_pkg::CFG_BITS-1:0]     cfg_data
);

  localparam int WE = (WINDOW_BITS > cwc_pkg::THRESH_BITS) ?
                      WINDOW_BITS : cwc_pkg::THRESH_BITS;

  // input register
  logic                          in_valid_r;
  cwc_pkg::mode_t                mode_r;
  logic [cwc_pkg::SEQ_BITS-1:0]  ack_r;

  // engine state
  logic [WINDOW_BITS-1:0]        window_r;
  logic [WINDOW_BITS-1:0]        window_nxt;
  cwc_pkg::cwc_state_t           state_r;
  cwc_pkg::cwc_state_t           state_nxt;
  cwc_pkg::cwc_flags_t           flags;
  logic [cwc_pkg::DUP_BITS-1:0]  dup_limit_r;

  // result register
  logic                          out_valid_r;
  logic [71:0]                   out_data_r;
  logic [WE-1:0]                 win_out;

  logic                          fire;
  logic                          cfg_fire;

  // advance the held event whenever the result slot is free or being drained
  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mode_r <= cwc_pkg::mode_t'(in_tuser);
      ack_r  <= in_tdata;
    end
  end

  cwc_update #(
    .WINDOW_BITS (WINDOW_BITS)
  ) u_update (
    .mode          (mode_r),
    .ack_number    (ack_r),
    .dup_ack_limit (dup_limit_r),
    .window_cur    (window_r),
    .state_cur     (state_r),
    .window_nxt    (window_nxt),
    .state_nxt     (state_nxt),
    .flags         (flags)
  );

  // state: the user must write config only while idle; not enforced, a write wins over an event
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r              <= WINDOW_BITS'(1);
      state_r.threshold     <= cwc_pkg::THRESH_RESET;
      state_r.base_seqno    <= '0;
      state_r.dup_count     <= '0;
      state_r.ss_active     <= 1'b1;
      state_r.last_ack_good <= 1'b1;
      dup_limit_r           <= cwc_pkg::DUP_LIMIT_RESET;
    end else if (cfg_fire) begin
      unique case (cwc_pkg::cfg_idx_t'(cfg_index))
        cwc_pkg::CFG_INITIAL_THRESHOLD: state_r.threshold <= cfg_data;
        cwc_pkg::CFG_DUP_ACK_LIMIT:     dup_limit_r <= cfg_data[cwc_pkg::DUP_BITS-1:0];
        default: begin
        end
      endcase
    end else if (fire) begin
      window_r <= window_nxt;
      state_r  <= state_nxt;
    end
  end

  // report the low 16 bits of the window
  assign win_out = WE'(window_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {5'd0,
                     flags.window_halved,
                     flags.duplicate_seen,
                     state_nxt.ss_active,
                     state_nxt.base_seqno,
                     state_nxt.threshold,
                     win_out[15:0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
